// ===== rtl/core/ssp_pkg.sv =====
// ssp_pkg: widths, constants, CORDIC stage type and small tables for the sunflower
// spiral point core. No dependencies.
package ssp_pkg;

  localparam int SEED_W           = 10;
  localparam int CENTER_W         = 12;
  localparam int POINT_W          = 18;
  localparam int SCALE_W          = 10;
  localparam int ANGLE_W          = 16;
  localparam int ROOT_W           = 16;
  localparam int RADIUS_W         = SCALE_W + ROOT_W;
  localparam int TRIG_W           = 32;
  localparam int CORDIC_STEPS     = 30;
  localparam int CORDIC_PER_STAGE = 4;
  localparam int CORDIC_STAGES    = 8;
  localparam int SQRT_STAGES      = 8;
  localparam int SQRT_PER_STAGE   = 2;
  localparam int ANGLE_STAGES     = 3;
  // radius waits for the trig path: angle + cordic vs sqrt + radius multiply
  localparam int RAD_DELAY        = ANGLE_STAGES + CORDIC_STAGES - SQRT_STAGES - 1;
  localparam int CENTER_DELAY     = ANGLE_STAGES + CORDIC_STAGES;

  localparam logic [SCALE_W-1:0]       SCALE_RESET  = 10'd192;
  localparam logic [15:0]              GOLD_NUM     = 16'd55;
  localparam logic [15:0]              DIV9_MUL     = 16'd58255; // ceil(2^19 / 9)
  localparam logic signed [TRIG_W-1:0] CORDIC_START = 32'sd652032874;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
    logic [1:0]               quad;
  } cordic_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic signed [TRIG_W-1:0] atan_turns(input int i);
    logic signed [TRIG_W-1:0] a;
    case (i)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      24: a = 32'sd41;
      25: a = 32'sd20;
      26: a = 32'sd10;
      27: a = 32'sd5;
      28: a = 32'sd3;
      29: a = 32'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // floor(r * 4096 / 9) plus the round-to-nearest carry for r >= 5
  function automatic logic [11:0] ninth_frac(input logic [3:0] r);
    logic [11:0] f;
    case (r)
      4'd0: f = 12'd0;
      4'd1: f = 12'd455;
      4'd2: f = 12'd910;
      4'd3: f = 12'd1365;
      4'd4: f = 12'd1820;
      4'd5: f = 12'd2276;
      4'd6: f = 12'd2731;
      4'd7: f = 12'd3186;
      4'd8: f = 12'd3641;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/ssp_angle.sv =====
// ssp_angle: golden-angle phase, t = round(n * 55 * 2^16 / 144) mod 2^16, in three stages.
// Depends on ssp_pkg.
module ssp_angle import ssp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  logic [SEED_W-1:0]  seed_i,
  output logic               valid_o,
  output logic [ANGLE_W-1:0] angle_o
);

  logic [ANGLE_STAGES-1:0] vld_r;
  logic [15:0]             m1_r;
  logic [15:0]             m2_r;
  logic [15:0]             q2_r;
  logic [ANGLE_W-1:0]      t_r;
  logic [31:0]             qprod;
  logic [15:0]             q9;
  logic [15:0]             rem_w;

  assign qprod = m1_r * {16'b0, DIV9_MUL};
  assign q9    = (q2_r << 3) + q2_r;
  assign rem_w = m2_r - q9;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ANGLE_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= 16'({6'b0, seed_i} * GOLD_NUM);
    m2_r <= m1_r;
    q2_r <= 16'(qprod >> 19);
    // n*55*4096 mod 9 equals n*55 mod 9 since 4096 mod 9 is 1
    t_r  <= {q2_r[3:0], 12'b0} + {4'b0, ninth_frac(rem_w[3:0])};
  end

  assign valid_o = vld_r[ANGLE_STAGES-1];
  assign angle_o = t_r;

endmodule

// ===== rtl/core/ssp_sqrt.sv =====
// ssp_sqrt: floor(sqrt(n * 2^16)) by restoring digit recurrence, two bits per stage.
// Depends on ssp_pkg.
module ssp_sqrt import ssp_pkg::*; (
  input  logic              clk,
  input  logic [SEED_W-1:0] seed_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [31:0]       v_r    [SQRT_STAGES];
  logic [17:0]       rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [31:0]       v_in;
    logic [17:0]       rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [31:0]       v_nxt;
    logic [17:0]       rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (g == 0) begin : g_first
      assign v_in    = {6'b0, seed_i, 16'b0};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    always_comb begin
      logic [19:0] rem2;
      logic [19:0] trial;
      v_nxt    = v_in;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
        rem2  = {rem_nxt, v_nxt[31:30]};
        trial = {2'b0, root_nxt, 2'b01};
        v_nxt = v_nxt << 2;
        if (rem2 >= trial) begin
          rem_nxt  = 18'(rem2 - trial);
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem2[17:0];
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      v_r[g]    <= v_nxt;
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
    end
  end

  assign root_o = root_r[SQRT_STAGES-1];

endmodule

// ===== rtl/core/ssp_cordic.sv =====
// ssp_cordic: quarter-turn fold plus 30 CORDIC rotations, four per stage (two in the last), Q30 cos/sin.
// Depends on ssp_pkg (cordic_t, atan_turns).
module ssp_cordic import ssp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  logic [ANGLE_W-1:0]       angle_i,
  output logic                     valid_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  cordic_t                  st_r [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] vld_r;
  cordic_t                  head;
  cordic_t                  last;

  assign head.x    = CORDIC_START;
  assign head.y    = '0;
  assign head.z    = {2'b00, angle_i[ANGLE_W-3:0], {(TRIG_W-ANGLE_W){1'b0}}};
  assign head.quad = angle_i[ANGLE_W-1:ANGLE_W-2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CORDIC_STAGES-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    cordic_t s_in;
    cordic_t s_nxt;

    if (g == 0) begin : g_first
      assign s_in = head;
    end else begin : g_next
      assign s_in = st_r[g-1];
    end

    always_comb begin
      int k;
      logic signed [TRIG_W-1:0] dx;
      logic signed [TRIG_W-1:0] dy;
      s_nxt = s_in;
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        k = g * CORDIC_PER_STAGE + j;
        if (k < CORDIC_STEPS) begin
          dx = s_nxt.y >>> k;
          dy = s_nxt.x >>> k;
          if (!s_nxt.z[TRIG_W-1]) begin
            s_nxt.x = s_nxt.x - dx;
            s_nxt.y = s_nxt.y + dy;
            s_nxt.z = s_nxt.z - atan_turns(k);
          end else begin
            s_nxt.x = s_nxt.x + dx;
            s_nxt.y = s_nxt.y - dy;
            s_nxt.z = s_nxt.z + atan_turns(k);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      st_r[g] <= s_nxt;
    end
  end

  assign last = st_r[CORDIC_STAGES-1];

  always_comb begin
    unique case (last.quad)
      2'd1: begin cos_o = -last.y; sin_o =  last.x; end
      2'd2: begin cos_o = -last.x; sin_o = -last.y; end
      2'd3: begin cos_o =  last.y; sin_o = -last.x; end
      default: begin cos_o = last.x; sin_o = last.y; end
    endcase
  end

  assign valid_o = vld_r[CORDIC_STAGES-1];

endmodule

// ===== rtl/core/sunflower_spiral_point_core.sv =====
// sunflower_spiral_point_core: Vogel spiral point = center + scale*sqrt(n)*(cos, sin).
// Depends on ssp_pkg, ssp_angle, ssp_sqrt, ssp_cordic.
// One word per cycle, busy is never high. The pipeline is the angle (3) + CORDIC (8) stages
// plus a radius * trig multiply stage and an add stage.
// Synchronous active-low reset clears the valid pipeline and sets spread_scale to 12.0.
module sunflower_spiral_point_core import ssp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [SEED_W-1:0]         in_seed_index,
  input  logic [CENTER_W-1:0]       in_center_x,
  input  logic [CENTER_W-1:0]       in_center_y,
  output logic                      out_valid,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y,
  input  logic                      cfg_we,
  input  logic [SCALE_W-1:0]        cfg_wdata
);

  logic [SCALE_W-1:0]       spread_scale_r;
  logic                     acc;
  logic                     ang_vld;
  logic [ANGLE_W-1:0]       ang;
  logic                     trig_vld;
  logic signed [TRIG_W-1:0] cos_w;
  logic signed [TRIG_W-1:0] sin_w;
  logic [ROOT_W-1:0]        root;
  logic [RADIUS_W-1:0]      rad_r;
  logic [RADIUS_W-1:0]      rad_d_r [RAD_DELAY];
  logic [CENTER_W-1:0]      cx_d_r  [CENTER_DELAY];
  logic [CENTER_W-1:0]      cy_d_r  [CENTER_DELAY];
  logic [RADIUS_W-1:0]      rad_al;

  logic                     p_vld_r;
  logic signed [42:0]       phx_r, phy_r;
  logic [41:0]              plx_r, ply_r;
  logic [CENTER_W-1:0]      pcx_r, pcy_r;
  logic signed [59:0]       sum_x, sum_y;

  localparam logic signed [59:0] ROUND_HALF = 60'sd1 <<< 37;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      spread_scale_r <= cfg_wdata;
    end
  end

  ssp_angle u_angle (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (acc),
    .seed_i  (in_seed_index),
    .valid_o (ang_vld),
    .angle_o (ang)
  );

  ssp_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (ang_vld),
    .angle_i (ang),
    .valid_o (trig_vld),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  ssp_sqrt u_sqrt (
    .clk    (clk),
    .seed_i (in_seed_index),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    rad_r <= {{(RADIUS_W-SCALE_W){1'b0}}, spread_scale_r} * {{(RADIUS_W-ROOT_W){1'b0}}, root};
    rad_d_r[0] <= rad_r;
    for (int i = 1; i < RAD_DELAY; i++) rad_d_r[i] <= rad_d_r[i-1];
    cx_d_r[0] <= in_center_x;
    cy_d_r[0] <= in_center_y;
    for (int i = 1; i < CENTER_DELAY; i++) begin
      cx_d_r[i] <= cx_d_r[i-1];
      cy_d_r[i] <= cy_d_r[i-1];
    end
  end

  assign rad_al = rad_d_r[RAD_DELAY-1];

  // radius * trig split at bit 16 of trig: signed high half, unsigned low half
  always_ff @(posedge clk) begin
    phx_r <= $signed({1'b0, rad_al}) * $signed(cos_w[TRIG_W-1:16]);
    phy_r <= $signed({1'b0, rad_al}) * $signed(sin_w[TRIG_W-1:16]);
    plx_r <= {16'b0, rad_al} * {26'b0, cos_w[15:0]};
    ply_r <= {16'b0, rad_al} * {26'b0, sin_w[15:0]};
    pcx_r <= cx_d_r[CENTER_DELAY-1];
    pcy_r <= cy_d_r[CENTER_DELAY-1];
  end

  assign sum_x = $signed({phx_r[42], phx_r, 16'b0}) + $signed({18'b0, plx_r}) + ROUND_HALF;
  assign sum_y = $signed({phy_r[42], phy_r, 16'b0}) + $signed({18'b0, ply_r}) + ROUND_HALF;

  always_ff @(posedge clk) begin
    out_point_x <= $signed({2'b00, pcx_r, 4'b0000}) + $signed(sum_x[55:38]);
    out_point_y <= $signed({2'b00, pcy_r, 4'b0000}) + $signed(sum_y[55:38]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_vld_r   <= trig_vld;
      out_valid <= p_vld_r;
    end
  end

  // a result only appears for a word that was accepted earlier
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 13))
    else $error("result without an accepted word");

  // index zero lands on the center exactly
  a_zero_is_center: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_seed_index == '0, 13)) |->
      (out_point_x == $past({2'b00, in_center_x, 4'b0000}, 13) &&
       out_point_y == $past({2'b00, in_center_y, 4'b0000}, 13)))
    else $error("index zero did not return the center");

  // accepted words reach the output without loss
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(acc, 13) && $past(rst_n, 13) && $past(rst_n, 1) &&
     $past(rst_n, 7) && $past(rst_n, 12)) |-> out_valid)
    else $error("accepted word was lost");

endmodule
